/* rtl/odec_pkg.sv */
package odec_pkg;

    // Addressing modes, as carried on address_mode
    typedef enum logic [3:0] {
        MODE_INH     = 4'd0,
        MODE_REG     = 4'd1,
        MODE_REG_IMM = 4'd2,
        MODE_IMM     = 4'd3,
        MODE_SRC     = 4'd4,
        MODE_REL     = 4'd5,
        MODE_CNT_REG = 4'd6,
        MODE_CRU_OFF = 4'd7,
        MODE_CNT_SRC = 4'd8,
        MODE_XOP_SRC = 4'd9,
        MODE_REG_SRC = 4'd10,
        MODE_DST_SRC = 4'd11
    } mode_t;

    localparam int WORD_W       = 16;
    localparam int IDX_W        = 7;
    localparam int MODE_W       = 4;
    localparam int OPTAB_COUNT  = 73;
    localparam logic [IDX_W-1:0] FALLBACK_IDX = 7'd73;

    // Match vector is split into groups of eight for the first-hit search
    localparam int GROUP_SIZE   = 8;
    localparam int LOCAL_W      = 3;
    localparam int GROUP_COUNT  = (OPTAB_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_W      = 4;

    typedef struct packed {
        logic [WORD_W-1:0] instruction_word;
    } word_t;

    typedef struct packed {
        logic [IDX_W-1:0]  mnemonic_index;
        logic [MODE_W-1:0] address_mode;
        logic              found;
    } result_t;

    typedef struct packed {
        logic [GROUP_COUNT-1:0]              hit;
        logic [GROUP_COUNT-1:0][LOCAL_W-1:0] local_idx;
    } group_t;

    localparam logic [WORD_W-1:0] OPTAB_BASE [0:OPTAB_COUNT-1] = '{
        16'h0080, 16'h0090, 16'h0180, 16'h01C0, 16'h0200, 16'h0220, 16'h0240, 16'h0260,
        16'h0280, 16'h02A0, 16'h02C0, 16'h02E0, 16'h0300, 16'h0340, 16'h0360, 16'h0380,
        16'h03A0, 16'h03C0, 16'h03E0, 16'h0400, 16'h0440, 16'h0480, 16'h04C0, 16'h0500,
        16'h0540, 16'h0580, 16'h05C0, 16'h0600, 16'h0640, 16'h0680, 16'h06C0, 16'h0700,
        16'h0740, 16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h1000, 16'h1100, 16'h1200,
        16'h1300, 16'h1400, 16'h1500, 16'h1600, 16'h1700, 16'h1800, 16'h1900, 16'h1A00,
        16'h1B00, 16'h1C00, 16'h1D00, 16'h1E00, 16'h1F00, 16'h2000, 16'h2400, 16'h2800,
        16'h2C00, 16'h3000, 16'h3400, 16'h3800, 16'h3C00, 16'h4000, 16'h5000, 16'h6000,
        16'h7000, 16'h8000, 16'h9000, 16'hA000, 16'hB000, 16'hC000, 16'hD000, 16'hE000,
        16'hF000
    };

    localparam mode_t OPTAB_MODE [0:OPTAB_COUNT-1] = '{
        MODE_REG,     MODE_REG,     MODE_SRC,     MODE_SRC,
        MODE_REG_IMM, MODE_REG_IMM, MODE_REG_IMM, MODE_REG_IMM,
        MODE_REG_IMM, MODE_REG,     MODE_REG,     MODE_IMM,
        MODE_IMM,     MODE_INH,     MODE_INH,     MODE_INH,
        MODE_INH,     MODE_INH,     MODE_INH,     MODE_SRC,
        MODE_SRC,     MODE_SRC,     MODE_SRC,     MODE_SRC,
        MODE_SRC,     MODE_SRC,     MODE_SRC,     MODE_SRC,
        MODE_SRC,     MODE_SRC,     MODE_SRC,     MODE_SRC,
        MODE_SRC,     MODE_CNT_REG, MODE_CNT_REG, MODE_CNT_REG,
        MODE_CNT_REG, MODE_REL,     MODE_REL,     MODE_REL,
        MODE_REL,     MODE_REL,     MODE_REL,     MODE_REL,
        MODE_REL,     MODE_REL,     MODE_REL,     MODE_REL,
        MODE_REL,     MODE_REL,     MODE_CRU_OFF, MODE_CRU_OFF,
        MODE_CRU_OFF, MODE_REG_SRC, MODE_REG_SRC, MODE_REG_SRC,
        MODE_XOP_SRC, MODE_CNT_SRC, MODE_CNT_SRC, MODE_REG_SRC,
        MODE_REG_SRC, MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC,
        MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC,
        MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC,
        MODE_DST_SRC
    };

    // Low operand bits that a mode leaves out of the compare
    function automatic logic [WORD_W-1:0] ignore_mask(input mode_t mode);
        logic [WORD_W-1:0] mask;
        case (mode)
            MODE_REG, MODE_REG_IMM:               mask = 16'h000F;
            MODE_SRC:                             mask = 16'h003F;
            MODE_REL, MODE_CNT_REG, MODE_CRU_OFF: mask = 16'h00FF;
            MODE_CNT_SRC, MODE_XOP_SRC, MODE_REG_SRC: mask = 16'h03FF;
            MODE_DST_SRC:                         mask = 16'h0FFF;
            default:                              mask = 16'h0000;
        endcase
        return mask;
    endfunction

endpackage

/* rtl/odec_word_if.sv */
interface odec_word_if;
    logic             valid;
    logic             ready;
    odec_pkg::word_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/odec_result_if.sv */
interface odec_result_if;
    logic              valid;
    logic              ready;
    odec_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/opcode_to_mnemonic_decode_core.sv */
// Opcode decoder: takes one 16-bit instruction word per cycle and returns the
// first entry of the fixed 73-entry opcode table that it matches, giving the
// mnemonic index, the addressing mode and a found flag. A word that matches no
// entry returns index 73 (macro-instruction detect), inherent mode and found
// low. Each word passes three register stages (masked compare, first hit
// within each group of eight entries, first group and mode lookup); the
// first stage loads at the edge that accepts the word, and the result is
// shown once the third has loaded. A new word may enter every cycle. The
// final stage is the output register, so words keep flowing into empty
// stages while a result waits to be taken; when every stage is full and the
// sink holds ready low, the input stalls without loss.
module opcode_to_mnemonic_decode_core (
    input  logic          clk,
    input  logic          rst_n,
    odec_word_if.sink     in_word,
    odec_result_if.source out_result
);

    // stage 1 to stage 2
    logic                             s1_valid;
    logic                             s1_ready;
    logic [odec_pkg::OPTAB_COUNT-1:0] s1_match;

    // stage 2 to stage 3
    logic                             s2_valid;
    logic                             s2_ready;
    odec_pkg::group_t                 s2_group;

    // compare every entry under its mode mask
    odec_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_word.ready),
        .word      (in_word.payload.instruction_word),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .match     (s1_match)
    );

    // reduce to one candidate per group of eight
    odec_prio u_prio (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .match     (s1_match),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .group     (s2_group)
    );

    // pick the lowest group, look up the mode, hold the result word
    odec_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .group     (s2_group),
        .out_valid (out_result.valid),
        .out_ready (out_result.ready),
        .result    (out_result.payload)
    );

endmodule

/* rtl/odec_match.sv */
// Stage 1: compare the word with every table entry under its mode mask
module odec_match (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [odec_pkg::WORD_W-1:0]         word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [odec_pkg::OPTAB_COUNT-1:0]    match
);

    logic                             valid_reg;
    logic [odec_pkg::OPTAB_COUNT-1:0] match_reg;
    logic [odec_pkg::OPTAB_COUNT-1:0] match_next;
    logic                             advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign match     = match_reg;

    always_comb
    begin
        for (int k = 0; k < odec_pkg::OPTAB_COUNT; k++)
        begin
            match_next[k] = ((word & ~odec_pkg::ignore_mask(odec_pkg::OPTAB_MODE[k]))
                             == odec_pkg::OPTAB_BASE[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // hold the match bits while the next stage stalls
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            match_reg <= match_next;
        end
    end

endmodule

/* rtl/odec_prio.sv */
// Stage 2: first hit inside each group of eight entries
module odec_prio (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [odec_pkg::OPTAB_COUNT-1:0] match,
    output logic                             out_valid,
    input  logic                             out_ready,
    output odec_pkg::group_t                 group
);

    logic             valid_reg;
    odec_pkg::group_t group_reg;
    odec_pkg::group_t group_next;
    logic             advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign group     = group_reg;

    always_comb
    begin
        group_next = '0;
        for (int g = 0; g < odec_pkg::GROUP_COUNT; g++)
        begin
            // walk downwards so the lowest matching entry is kept
            for (int j = odec_pkg::GROUP_SIZE - 1; j >= 0; j--)
            begin
                if ((g * odec_pkg::GROUP_SIZE + j) < odec_pkg::OPTAB_COUNT)
                begin
                    if (match[g * odec_pkg::GROUP_SIZE + j])
                    begin
                        group_next.hit[g]       = 1'b1;
                        group_next.local_idx[g] = odec_pkg::LOCAL_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            group_reg <= group_next;
        end
    end

endmodule

/* rtl/odec_select.sv */
// Stage 3: first group with a hit, mode lookup, output register
module odec_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  odec_pkg::group_t  group,
    output logic              out_valid,
    input  logic              out_ready,
    output odec_pkg::result_t result
);

    logic                           valid_reg;
    odec_pkg::result_t              result_reg;
    odec_pkg::result_t              result_next;
    logic                           advance;
    logic [odec_pkg::GROUP_W-1:0]   sel_group;
    logic                           any_hit;
    logic [odec_pkg::IDX_W-1:0]     hit_idx;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        sel_group = '0;
        any_hit   = 1'b0;
        for (int g = odec_pkg::GROUP_COUNT - 1; g >= 0; g--)
        begin
            if (group.hit[g])
            begin
                sel_group = odec_pkg::GROUP_W'(g);
                any_hit   = 1'b1;
            end
        end
        hit_idx = odec_pkg::IDX_W'({sel_group, group.local_idx[sel_group]});

        if (any_hit)
        begin
            result_next.mnemonic_index = hit_idx;
            result_next.address_mode   = odec_pkg::OPTAB_MODE[hit_idx];
            result_next.found          = 1'b1;
        end
        else
        begin
            result_next.mnemonic_index = odec_pkg::FALLBACK_IDX;
            result_next.address_mode   = odec_pkg::MODE_INH;
            result_next.found          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* tb/sv/tb_opcode_to_mnemonic_decode_core.sv */
`timescale 1ns / 1ps

module tb_opcode_to_mnemonic_decode_core;
    import odec_pkg::*;

    localparam int              CLK_HALF_NS      = 6;
    localparam int              RESET_CYCLES     = 10;
    localparam int              RANDOM_WORDS     = 1880;
    localparam int              MAX_WAIT         = 12;
    localparam int              CALM_STRETCH     = 150;
    localparam int              DRAIN_CYCLES     = 16;
    localparam int              CYCLE_LIMIT      = 400000;
    localparam int              REPORT_LIMIT     = 10;
    localparam int              TABLE_ROWS       = 73;
    localparam int              DIRECTED_COUNT   = 24;
    localparam logic [IDX_W-1:0] MACRO_DETECT_IDX = 7'd73;

    // Opcode table in search order: base code and addressing mode of each row.
    // The decoder's own copy is not used, so a wrong row in the RTL shows up.
    localparam logic [WORD_W-1:0] OPCODE_BASE [0:TABLE_ROWS-1] = '{
        16'h0080, 16'h0090, 16'h0180, 16'h01C0, 16'h0200, 16'h0220, 16'h0240, 16'h0260,
        16'h0280, 16'h02A0, 16'h02C0, 16'h02E0, 16'h0300, 16'h0340, 16'h0360, 16'h0380,
        16'h03A0, 16'h03C0, 16'h03E0, 16'h0400, 16'h0440, 16'h0480, 16'h04C0, 16'h0500,
        16'h0540, 16'h0580, 16'h05C0, 16'h0600, 16'h0640, 16'h0680, 16'h06C0, 16'h0700,
        16'h0740, 16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h1000, 16'h1100, 16'h1200,
        16'h1300, 16'h1400, 16'h1500, 16'h1600, 16'h1700, 16'h1800, 16'h1900, 16'h1A00,
        16'h1B00, 16'h1C00, 16'h1D00, 16'h1E00, 16'h1F00, 16'h2000, 16'h2400, 16'h2800,
        16'h2C00, 16'h3000, 16'h3400, 16'h3800, 16'h3C00, 16'h4000, 16'h5000, 16'h6000,
        16'h7000, 16'h8000, 16'h9000, 16'hA000, 16'hB000, 16'hC000, 16'hD000, 16'hE000,
        16'hF000
    };

    localparam mode_t OPCODE_MODE [0:TABLE_ROWS-1] = '{
        MODE_REG,     MODE_REG,     MODE_SRC,     MODE_SRC,
        MODE_REG_IMM, MODE_REG_IMM, MODE_REG_IMM, MODE_REG_IMM,
        MODE_REG_IMM, MODE_REG,     MODE_REG,     MODE_IMM,
        MODE_IMM,     MODE_INH,     MODE_INH,     MODE_INH,
        MODE_INH,     MODE_INH,     MODE_INH,     MODE_SRC,
        MODE_SRC,     MODE_SRC,     MODE_SRC,     MODE_SRC,
        MODE_SRC,     MODE_SRC,     MODE_SRC,     MODE_SRC,
        MODE_SRC,     MODE_SRC,     MODE_SRC,     MODE_SRC,
        MODE_SRC,     MODE_CNT_REG, MODE_CNT_REG, MODE_CNT_REG,
        MODE_CNT_REG, MODE_REL,     MODE_REL,     MODE_REL,
        MODE_REL,     MODE_REL,     MODE_REL,     MODE_REL,
        MODE_REL,     MODE_REL,     MODE_REL,     MODE_REL,
        MODE_REL,     MODE_REL,     MODE_CRU_OFF, MODE_CRU_OFF,
        MODE_CRU_OFF, MODE_REG_SRC, MODE_REG_SRC, MODE_REG_SRC,
        MODE_XOP_SRC, MODE_CNT_SRC, MODE_CNT_SRC, MODE_REG_SRC,
        MODE_REG_SRC, MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC,
        MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC,
        MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC, MODE_DST_SRC,
        MODE_DST_SRC
    };

    // Hand-picked words: all-zero and all-one, each addressing mode with its
    // operand field empty or full, inherent and immediate forms with a stray
    // low bit, and words in holes of the table that must fall back.
    localparam logic [WORD_W-1:0] DIRECTED_WORDS [0:DIRECTED_COUNT-1] = '{
        16'h0000, 16'hFFFF, 16'h0080, 16'h009F, 16'h01BF, 16'h020F,
        16'h02A5, 16'h02E0, 16'h02E1, 16'h0300, 16'h0340, 16'h03E0,
        16'h03E8, 16'h077F, 16'h0BFF, 16'h1CFF, 16'h1D80, 16'h1FFF,
        16'h2C00, 16'h33FF, 16'h3FFF, 16'h4000, 16'h00A0, 16'h0C00
    };

    // An expected result together with the word that produced it
    typedef struct {
        logic [WORD_W-1:0] source_word;
        result_t           outcome;
    } decoded_t;

    logic clk;
    logic rst_n;

    odec_word_if   word_ch ();
    odec_result_if result_ch ();

    opcode_to_mnemonic_decode_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_word    (word_ch),
        .out_result (result_ch)
    );

    logic [WORD_W-1:0] pending_words [$];
    decoded_t          decoded_expect [$];

    int       total_words   = 0;
    int       words_sent    = 0;
    int       results_seen  = 0;
    int       matched_count = 0;
    int       macro_count   = 0;
    int       fault_count   = 0;
    int       cycle_count   = 0;
    int       send_gap      = 0;
    int       take_stall    = 0;
    decoded_t want;
    result_t  got;

    // Operand bits that an addressing mode leaves out of the compare
    function automatic logic [WORD_W-1:0] operand_field(input mode_t mode);
        case (mode)
            MODE_REG, MODE_REG_IMM:                   return 16'h000F;
            MODE_SRC:                                 return 16'h003F;
            MODE_REL, MODE_CNT_REG, MODE_CRU_OFF:     return 16'h00FF;
            MODE_CNT_SRC, MODE_XOP_SRC, MODE_REG_SRC: return 16'h03FF;
            MODE_DST_SRC:                             return 16'h0FFF;
            default:                                  return 16'h0000;
        endcase
    endfunction

    // Walk the table from the bottom up so that the row nearest the top wins
    // where rows overlap; no hit at all leaves the macro-detect fallback.
    function automatic result_t decode_opcode(input logic [WORD_W-1:0] word);
        result_t r;
        r.mnemonic_index = MACRO_DETECT_IDX;
        r.address_mode   = MODE_INH;
        r.found          = 1'b0;
        for (int k = TABLE_ROWS - 1; k >= 0; k--)
        begin
            if ((word & ~operand_field(OPCODE_MODE[k])) == OPCODE_BASE[k])
            begin
                r.mnemonic_index = IDX_W'(k);
                r.address_mode   = OPCODE_MODE[k];
                r.found          = 1'b1;
            end
        end
        return r;
    endfunction

    // Every third stretch of words runs with no idling at all
    function automatic int draw_wait(input int progress);
        if ((progress / CALM_STRETCH) % 3 == 2)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Driver: present queued words, hold each until taken, then idle for
    // the drawn gap before the next one. Record the prediction on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            word_ch.valid <= 1'b0;
        end
        else
        begin
            if (word_ch.valid && word_ch.ready)
            begin
                decoded_expect.push_back(decoded_t'{word_ch.payload.instruction_word,
                                         decode_opcode(word_ch.payload.instruction_word)});
                words_sent++;
            end
            // Advance only when nothing is on the bus or the current word was taken
            if (!word_ch.valid || word_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    word_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    word_ch.payload.instruction_word <= pending_words.pop_front();
                    word_ch.valid <= 1'b1;
                    send_gap = draw_wait(words_sent);
                end
                else
                begin
                    word_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction,
    // then drop ready for the drawn stall before taking the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (decoded_expect.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected result: idx %0d mode %0d found %0b",
                                 got.mnemonic_index, got.address_mode, got.found);
                end
                else
                begin
                    want = decoded_expect.pop_front();
                    if (got.mnemonic_index !== want.outcome.mnemonic_index ||
                        got.address_mode   !== want.outcome.address_mode ||
                        got.found          !== want.outcome.found)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display({"mismatch on word %04h: expected idx %0d mode %0d",
                                      " found %0b, got idx %0d mode %0d found %0b"},
                                     want.source_word, want.outcome.mnemonic_index,
                                     want.outcome.address_mode, want.outcome.found,
                                     got.mnemonic_index, got.address_mode, got.found);
                    end
                    if (want.outcome.found)
                        matched_count++;
                    else
                        macro_count++;
                end
                results_seen++;
                take_stall = draw_wait(results_seen);
            end
            if (take_stall > 0)
            begin
                take_stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that reaches CYCLE_LIMIT ends as failed
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("opcode_to_mnemonic_decode_core verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] word;
        int                row;

        clk                              = 1'b0;
        rst_n                            = 1'b0;
        word_ch.valid                    = 1'b0;
        word_ch.payload.instruction_word = '0;
        result_ch.ready                  = 1'b0;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            pending_words.push_back(DIRECTED_WORDS[i]);

        // Mostly real opcodes with random operand fields; the rest raw noise,
        // which also lands in the holes of the table.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                row  = $urandom_range(0, TABLE_ROWS - 1);
                word = OPCODE_BASE[row] | (WORD_W'($urandom) & operand_field(OPCODE_MODE[row]));
            end
            else
            begin
                word = WORD_W'($urandom);
            end
            pending_words.push_back(word);
        end
        total_words = pending_words.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every word is taken and every prediction has been met
        while (words_sent < total_words)
            @(posedge clk);
        while (decoded_expect.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d instruction words (%0d directed): %0d table hits, %0d fallbacks.",
                 results_seen, DIRECTED_COUNT, matched_count, macro_count);
        $display("Result faults counted: %0d.", fault_count);
        if (fault_count == 0)
            $display("opcode_to_mnemonic_decode_core verification clean");
        else
            $display("opcode_to_mnemonic_decode_core verification failed");
        $finish;
    end

endmodule
